// File: sv/sbb_pkg.sv
// shared types and constants for the separable box blur
`timescale 1ns / 1ps
package sbb_pkg;
	localparam int unsigned PIX_W = 32;
	typedef enum logic [3:0] {
		ST_IDLE, ST_POS_DIV, ST_ROW_RD, ST_ROW_WAIT, ST_ROW_ACC, ST_ROW_DIV,
		ST_COL_ACC, ST_COL_DIV, ST_OUT
	} sbb_state_t;
	typedef enum logic [1:0] {
		REG_WIDTH = 2'd0, REG_HEIGHT = 2'd1, REG_RADIUS = 2'd2
	} sbb_reg_t;
	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [8:0]  divisor;
	} sbb_div_req_t;
endpackage

// File: sv/sbb_ram.sv
// generic ram with one write port, one read port and registered read
`timescale 1ns / 1ps
module sbb_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// File: sv/sbb_div.sv
// restoring divider, one quotient bit per cycle, shared by all passes
`timescale 1ns / 1ps
module sbb_div
	import sbb_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  sbb_div_req_t req,
	output logic         busy,
	output logic [31:0]  quot,
	output logic [8:0]   rem
);
	logic [31:0] q_q;
	logic [9:0]  rem_q;
	logic [8:0]  dvs_q;
	logic [5:0]  cnt_q;
	logic [9:0]  trial;
	logic        ge;
	always_comb begin
		trial = {rem_q[8:0], q_q[31]};
		ge    = trial >= {1'b0, dvs_q};
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= 6'd32;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end
	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q   <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? trial - {1'b0, dvs_q} : trial;
			q_q   <= {q_q[30:0], ge};
		end
	end
	assign busy = (cnt_q != '0) || req.start;
	assign quot = q_q;
	assign rem  = rem_q[8:0];
endmodule

// File: sv/separable_box_blur.sv
// separable box blur top level: frame store, sequencer and shared divider
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_stall  | req_type, in_alpha..in_blue
//  output   | out_valid/ out_stall | out_alpha..out_blue, frame_done
//  config   | apb psel/penable     | paddr, pwdata, prdata
//
// a load is written to the frame store as it is accepted; an emit first splits its
// position into row and column with one divide, then per channel reads (2r+1)^2
// pixels (read, wait, add) and runs 2r+2 divides; its own state starts the last one
// the word sits in the output register until out_stall drops; in_stall stays high
// from accepting an emit until the word leaves, so one item is in flight at a time
// reset clears positions, restores config defaults; the frame store is not cleared
`timescale 1ns / 1ps
module separable_box_blur
	import sbb_pkg::*;
#(
	parameter int unsigned MAX_WIDTH  = 256,
	parameter int unsigned MAX_HEIGHT = 256,
	parameter int unsigned MAX_RADIUS = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [7:0]  in_alpha,
	input  logic [7:0]  in_red,
	input  logic [7:0]  in_green,
	input  logic [7:0]  in_blue,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_alpha,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic        frame_done
);
	localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned PW    = $clog2(DEPTH + 1);

	logic [8:0] width_q, height_q;
	logic [5:0] radius_q;
	logic [PW-1:0] load_q, emit_q;
	sbb_state_t state_q, state_d;

	// geometry, clamped
	logic [12:0] w_eff, h_eff, m_eff;
	logic [7:0]  r_eff;
	logic [8:0]  span;
	logic [25:0] total;
	always_comb begin
		w_eff = (width_q == '0) ? 13'd1 :
			((13'(width_q) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(width_q));
		h_eff = (height_q == '0) ? 13'd1 :
			((13'(height_q) > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : 13'(height_q));
		m_eff = ((w_eff < h_eff) ? w_eff : h_eff) >> 1;
		r_eff = (8'(radius_q) > 8'(MAX_RADIUS)) ? 8'(MAX_RADIUS) : 8'(radius_q);
		if (13'(r_eff) > m_eff) r_eff = 8'(m_eff);
		span  = {r_eff, 1'b1};
		total = 26'(w_eff * h_eff);
	end

	// apb
	assign pready = 1'b1;
	always_comb begin
		case (paddr[3:2])
			REG_WIDTH:  prdata = 32'(width_q);
			REG_HEIGHT: prdata = 32'(height_q);
			REG_RADIUS: prdata = 32'(radius_q);
			default:    prdata = '0;
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd256;
			height_q <= 9'd256;
			radius_q <= 6'd1;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			case (paddr[3:2])
				REG_WIDTH:  width_q  <= pwdata[8:0];
				REG_HEIGHT: height_q <= pwdata[8:0];
				REG_RADIUS: radius_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	// position counters and loop indices
	logic [12:0] px_q, py_q;
	logic [8:0]  dy_q, dx_q;
	logic [1:0]  ch_q;
	logic [16:0] hsum_q;
	logic [15:0] vsum_q;
	logic [7:0]  res_q [4];
	logic        done_q;

	logic in_acc, is_load, load_ok;
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign is_load  = !req_type;
	assign load_ok  = 26'(load_q) < total;

	// memory
	logic          we;
	logic [AW-1:0] raddr;
	logic [31:0]   rdata;
	assign we = in_acc && is_load && load_ok;
	sbb_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_store (
		.clk(clk), .we(we), .waddr(AW'(load_q)),
		.wdata({in_alpha, in_red, in_green, in_blue}),
		.raddr(raddr), .rdata(rdata)
	);

	// clamped tap coordinates
	logic signed [14:0] xs, ys;
	logic [12:0] xc, yc;
	always_comb begin
		xs = $signed({2'b0, px_q}) + $signed({6'b0, dx_q}) - $signed({7'b0, r_eff});
		ys = $signed({2'b0, py_q}) + $signed({6'b0, dy_q}) - $signed({7'b0, r_eff});
		xc = (xs < 0) ? '0 : ((xs > $signed({2'b0, w_eff}) - 15'sd1) ?
			w_eff - 13'd1 : 13'(xs));
		yc = (ys < 0) ? '0 : ((ys > $signed({2'b0, h_eff}) - 15'sd1) ?
			h_eff - 13'd1 : 13'(ys));
		raddr = AW'(yc * w_eff + xc);
	end

	// divider
	sbb_div_req_t dreq;
	logic         dbusy;
	logic [31:0]  dquot;
	logic [8:0]   drem;
	sbb_div u_div (
		.clk(clk), .arst_n(arst_n), .req(dreq), .busy(dbusy), .quot(dquot), .rem(drem)
	);

	logic [7:0] chan_byte;
	always_comb begin
		case (ch_q)
			2'd0:    chan_byte = rdata[31:24];
			2'd1:    chan_byte = rdata[23:16];
			2'd2:    chan_byte = rdata[15:8];
			default: chan_byte = rdata[7:0];
		endcase
	end

	logic last_dx, last_dy;
	assign last_dx = dx_q == {r_eff, 1'b0};
	assign last_dy = dy_q == {r_eff, 1'b0};

	always_comb begin
		state_d       = state_q;
		dreq.start    = 1'b0;
		dreq.dividend = 32'(hsum_q);
		dreq.divisor  = span;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && !is_load && 26'(emit_q) < total) begin
					// row and column of the position under the current width
					dreq.start    = 1'b1;
					dreq.dividend = 32'(emit_q);
					dreq.divisor  = w_eff[8:0];
					state_d       = ST_POS_DIV;
				end
			end
			ST_POS_DIV: begin
				if (!dbusy) state_d = ST_ROW_RD;
			end
			ST_ROW_RD:   state_d = ST_ROW_WAIT;
			ST_ROW_WAIT: state_d = ST_ROW_ACC;
			ST_ROW_ACC: begin
				if (last_dx) begin
					dreq.start    = 1'b1;
					dreq.dividend = 32'(hsum_q) + 32'(chan_byte);
					state_d       = ST_ROW_DIV;
				end else begin
					state_d = ST_ROW_RD;
				end
			end
			ST_ROW_DIV: begin
				if (!dbusy) state_d = last_dy ? ST_COL_ACC : ST_ROW_RD;
			end
			ST_COL_ACC: begin
				dreq.start    = 1'b1;
				dreq.dividend = 32'(vsum_q);
				state_d       = ST_COL_DIV;
			end
			ST_COL_DIV: begin
				if (!dbusy) state_d = (ch_q == 2'd3) ? ST_OUT : ST_ROW_RD;
			end
			ST_OUT: begin
				if (!out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			load_q  <= '0;
			emit_q  <= '0;
			px_q    <= '0;
			py_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (we) load_q <= load_q + PW'(1);
			if (state_q == ST_IDLE && state_d == ST_POS_DIV) begin
				done_q <= 26'(emit_q) == total - 26'd1;
			end
			if (state_q == ST_POS_DIV && !dbusy) begin
				px_q <= 13'(drem);
				py_q <= dquot[12:0];
			end
			if (state_q == ST_OUT && !out_stall) begin
				emit_q <= emit_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				dx_q <= '0; dy_q <= '0; ch_q <= '0; hsum_q <= '0; vsum_q <= '0;
			end
			ST_ROW_ACC: begin
				if (last_dx) begin
					dx_q <= '0; hsum_q <= '0;
				end else begin
					dx_q <= dx_q + 9'd1;
					hsum_q <= hsum_q + 17'(chan_byte);
				end
			end
			ST_ROW_DIV: begin
				if (!dbusy) begin
					vsum_q <= vsum_q + 16'(dquot);
					dy_q   <= last_dy ? dy_q : dy_q + 9'd1;
				end
			end
			ST_COL_DIV: begin
				if (!dbusy) begin
					res_q[ch_q] <= dquot[7:0];
					ch_q <= ch_q + 2'd1;
					dy_q <= '0; vsum_q <= '0;
				end
			end
			default: ;
		endcase
	end

	assign out_valid  = state_q == ST_OUT;
	assign out_alpha  = res_q[0];
	assign out_red    = res_q[1];
	assign out_green  = res_q[2];
	assign out_blue   = res_q[3];
	assign frame_done = done_q;
endmodule

// File: sim/tb.sv
// self-checking testbench for the separable box blur: one frame, geometry changed between phases
`timescale 1ns / 1ps
module tb
	import sbb_pkg::*;
;

	typedef enum bit {REQ_LOAD = 1'b0, REQ_EMIT = 1'b1} req_kind_t;
	typedef struct {
		req_kind_t kind;
		bit [7:0] a, r, g, b;
	} pix_req_t;
	typedef struct {
		bit [7:0] a, r, g, b;
		bit done;
	} blur_pix_t;

	localparam int unsigned FRAME_MAX = 256;
	localparam int unsigned RAD_MAX = 63;
	localparam int unsigned STALL_LIMIT = 60000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0, in_stall;
	logic req_type = 1'b0;
	logic [7:0] in_alpha = '0, in_red = '0, in_green = '0, in_blue = '0;
	logic out_valid, out_stall = 1'b0;
	logic [7:0] out_alpha, out_red, out_green, out_blue;
	logic frame_done;

	separable_box_blur DUT (.*);

	// register copies shared by the stimulus shaping and the blur predictor
	int unsigned cfg_width = 256, cfg_height = 256, cfg_radius = 1;
	bit [31:0] frame_mem [FRAME_MAX*FRAME_MAX];
	int unsigned pred_load = 0, pred_emit = 0;
	int unsigned gen_load = 0, gen_emit = 0;

	pix_req_t pending_q[$];
	blur_pix_t blurred_q[$];
	pix_req_t cur_req;
	int errors = 0;
	int results_seen = 0;
	int idle_cycles = 0;
	int burst_left = 0, gap_left = 0;
	int stall_pct = 0, stall_timer = 0, holdoff = 0;
	bit held_off = 1'b0;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int unsigned eff_dim(int unsigned v);
		if (v == 0) return 1;
		if (v > FRAME_MAX) return FRAME_MAX;
		return v;
	endfunction

	function automatic int unsigned eff_radius();
		int unsigned w, h, m, rad;
		w = eff_dim(cfg_width);
		h = eff_dim(cfg_height);
		rad = (cfg_radius > RAD_MAX) ? RAD_MAX : cfg_radius;
		m = ((w < h) ? w : h) / 2;
		return (rad > m) ? m : rad;
	endfunction

	function automatic int clampi(int v, int lim);
		if (v < 0) return 0;
		if (v > lim - 1) return lim - 1;
		return v;
	endfunction

	// horizontal then vertical average of one channel, both truncating
	function automatic bit [7:0] blur_channel(int px, int py, int rad, int w, int h, int shift);
		int unsigned span, col_sum, row_sum;
		int x, y;
		span = 2 * rad + 1;
		col_sum = 0;
		for (int dy = -rad; dy <= rad; dy++) begin
			y = clampi(py + dy, h);
			row_sum = 0;
			for (int dx = -rad; dx <= rad; dx++) begin
				x = clampi(px + dx, w);
				row_sum += (frame_mem[y * w + x] >> shift) & 8'hFF;
			end
			col_sum += row_sum / span;
		end
		return col_sum / span;
	endfunction

	task automatic blur_accept(pix_req_t it);
		int unsigned w, h, total, rad;
		blur_pix_t res;
		w = eff_dim(cfg_width);
		h = eff_dim(cfg_height);
		total = w * h;
		if (it.kind == REQ_LOAD) begin
			if (pred_load < total) begin
				frame_mem[pred_load] = {it.a, it.r, it.g, it.b};
				pred_load++;
			end
		end else if (pred_emit < total) begin
			rad = eff_radius();
			res.a = blur_channel(pred_emit % w, pred_emit / w, rad, w, h, 24);
			res.r = blur_channel(pred_emit % w, pred_emit / w, rad, w, h, 16);
			res.g = blur_channel(pred_emit % w, pred_emit / w, rad, w, h, 8);
			res.b = blur_channel(pred_emit % w, pred_emit / w, rad, w, h, 0);
			res.done = (pred_emit == total - 1);
			blurred_q.push_back(res);
			pred_emit++;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				blur_accept(cur_req);
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					cur_req = pending_q.pop_front();
					req_type <= cur_req.kind;
					in_alpha <= cur_req.a;
					in_red <= cur_req.r;
					in_green <= cur_req.g;
					in_blue <= cur_req.b;
					in_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern, with one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (stall_timer == 0) begin
				stall_timer = $urandom_range(50, 400);
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 30;
					default: stall_pct = 75;
				endcase
			end else begin
				stall_timer--;
			end
			if (holdoff > 0) begin
				holdoff--;
				out_stall <= 1'b1;
			end else if (!held_off && results_seen >= 200) begin
				held_off = 1'b1;
				holdoff = 3000;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (blurred_q.size() == 0) begin
				$error("unexpected word: a=%0h r=%0h g=%0h b=%0h", out_alpha, out_red,
					out_green, out_blue);
				errors++;
			end else begin
				blur_pix_t want;
				want = blurred_q.pop_front();
				if (out_alpha !== want.a) begin
					$error("out_alpha: expected %0h got %0h", want.a, out_alpha);
					errors++;
				end
				if (out_red !== want.r) begin
					$error("out_red: expected %0h got %0h", want.r, out_red);
					errors++;
				end
				if (out_green !== want.g) begin
					$error("out_green: expected %0h got %0h", want.g, out_green);
					errors++;
				end
				if (out_blue !== want.b) begin
					$error("out_blue: expected %0h got %0h", want.b, out_blue);
					errors++;
				end
				if (frame_done !== want.done) begin
					$error("frame_done: expected %0b got %0b", want.done, frame_done);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("separable_box_blur regression: fail");
			$finish;
		end
	end

	task automatic reg_write(sbb_reg_t idx, int unsigned val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_WIDTH: cfg_width = val & 9'h1FF;
			REG_HEIGHT: cfg_height = val & 9'h1FF;
			REG_RADIUS: cfg_radius = val & 6'h3F;
			default: ;
		endcase
	endtask

	task automatic set_geometry(int unsigned w, int unsigned h, int unsigned rad);
		reg_write(REG_WIDTH, w);
		reg_write(REG_HEIGHT, h);
		reg_write(REG_RADIUS, rad);
	endtask

	task automatic push_req(req_kind_t kind, bit [31:0] argb);
		pix_req_t it;
		it.kind = kind;
		{it.a, it.r, it.g, it.b} = argb;
		pending_q.push_back(it);
	endtask

	// quiet the block: input side empty, every word back, then a margin
	task automatic settle();
		while (pending_q.size() > 0 || in_valid || blurred_q.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// an emit is legal only once every pixel of its window has been loaded
	function automatic bit emit_ready();
		int unsigned w, h, rad, last_row;
		w = eff_dim(cfg_width);
		h = eff_dim(cfg_height);
		rad = eff_radius();
		if (gen_emit >= w * h) return 1'b0;
		last_row = gen_emit / w + rad;
		if (last_row > h - 1) last_row = h - 1;
		return (last_row * w + w - 1) < gen_load;
	endfunction

	task automatic random_phase(int unsigned n);
		int unsigned total, done_n;
		bit can_load, can_emit;
		total = eff_dim(cfg_width) * eff_dim(cfg_height);
		done_n = 0;
		while (done_n < n) begin
			can_emit = emit_ready();
			can_load = gen_load < total;
			if ($urandom_range(0, 99) < 4 && (!can_load || gen_emit >= total)) begin
				// ignored traffic past the end of the frame
				push_req(can_load ? REQ_EMIT : REQ_LOAD, $urandom);
			end else if (can_emit && (!can_load || $urandom_range(0, 1))) begin
				push_req(REQ_EMIT, $urandom);
				gen_emit++;
				done_n++;
			end else if (can_load) begin
				push_req(REQ_LOAD, $urandom);
				gen_load++;
				done_n++;
			end else begin
				break;
			end
		end
		settle();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: 4x3 pass-through, extreme pixels, overrun on both sides
		set_geometry(4, 3, 0);
		reg_write(sbb_reg_t'(3), 32'hFFFF_FFFF);
		push_req(REQ_LOAD, 32'hFFFF_FFFF);
		push_req(REQ_LOAD, 32'h0000_0000);
		push_req(REQ_LOAD, 32'hAA55_AA55);
		push_req(REQ_LOAD, 32'h55AA_55AA);
		repeat (8) push_req(REQ_LOAD, $urandom);
		push_req(REQ_LOAD, 32'h1234_5678);
		repeat (12) push_req(REQ_EMIT, $urandom);
		push_req(REQ_EMIT, 32'h0);
		gen_load = 12;
		gen_emit = 12;
		settle();

		// width zero counts as one column; radius clipped to zero
		set_geometry(0, 40, 5);
		random_phase(60);
		// oversized width, zero height, full radius request
		set_geometry(511, 0, 63);
		random_phase(300);
		set_geometry(16, 20, 1);
		random_phase(250);
		set_geometry(18, 24, 2);
		random_phase(200);
		// large radius clipped by the smaller dimension
		set_geometry(30, 16, 40);
		random_phase(60);
		set_geometry(32, 24, 1);
		random_phase(560);

		settle();
		if (errors == 0)
			$display("separable_box_blur regression: pass");
		else
			$display("separable_box_blur regression: fail");
		$finish;
	end

endmodule

// File: sim.f
sv/sbb_pkg.sv
sv/sbb_ram.sv
sv/sbb_div.sv
sv/separable_box_blur.sv
sim/tb.sv
